/* rtl/chained_page_allocator_assert.svh */
// assertion macros shared by the chained page allocator modules
// needs clk_i and rst_ni in the scope of each use
`ifndef CHAINED_PAGE_ALLOCATOR_ASSERT_SVH
`define CHAINED_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define CPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpa assertion failed");

// next-cycle implication, off during reset
`define CPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpa assertion failed");

`endif

/* rtl/cpa_pkg.sv */
// shared constants, codes and control structs of the chained page allocator
// no dependencies
`default_nettype none

package cpa_pkg;

  localparam int PAGES      = 16;
  localparam int PAGE_BYTES = 16;

  // fixed field widths of the transaction ports
  localparam int CMD_FW   = 2;
  localparam int SIZE_FW  = 12;
  localparam int PAGE_FW  = 4;
  localparam int COUNT_FW = 5;

  // internal widths; index and count widths follow the table size
  localparam int IDX_W  = $clog2(PAGES);
  localparam int CNT_W  = $clog2(PAGES + 1);
  localparam int NEED_W = SIZE_FW + 1;

  typedef enum logic [CMD_FW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_SIZE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NOT_USED  = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step_alloc;
    logic step_walk;
    logic publish;
  } cpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic imm;
    logic is_alloc;
    logic alloc_last;
    logic walk_stop;
  } cpa_stat_t;

endpackage

`default_nettype wire

/* rtl/cpa_ctrl.sv */
// controller state machine of the chained page allocator
// depends on cpa_pkg
`default_nettype none

module cpa_ctrl
  import cpa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire cpa_stat_t stat_i,
  output cpa_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_WALK,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.imm) begin
            state_d = S_DONE;
          end else if (stat_i.is_alloc) begin
            state_d = S_ALLOC;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_ALLOC: begin
        cmd_o.step_alloc = 1'b1;
        if (stat_i.alloc_last) begin
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        cmd_o.step_walk = 1'b1;
        if (stat_i.walk_stop) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // wait until the output register can take the result
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`include "chained_page_allocator_assert.svh"

  `CPA_ASSERT_IMPL(a_no_overwrite, out_valid_q && !out_ready_i, !cmd_o.publish)
  `CPA_ASSERT_NEXT(a_alloc_ends, state_q == S_ALLOC && stat_i.alloc_last, state_q == S_DONE)
  `CPA_ASSERT_IMPL(a_publish_done, cmd_o.publish, state_q == S_DONE)

endmodule

`default_nettype wire

/* rtl/cpa_dpath.sv */
// datapath of the chained page allocator: page table, scan and walk registers,
// result and output registers; depends on cpa_pkg
`default_nettype none

module cpa_dpath
  import cpa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [CMD_FW-1:0]   cmd_i,
  input  wire logic [SIZE_FW-1:0]  size_bytes_i,
  input  wire logic [PAGE_FW-1:0]  head_page_i,
  input  wire cpa_cmd_t            cmd_ctl_i,
  output cpa_stat_t                stat_o,
  output logic [1:0]               status_o,
  output logic [PAGE_FW-1:0]       first_page_o,
  output logic [COUNT_FW-1:0]      page_count_o,
  output logic [COUNT_FW-1:0]      free_pages_o
);

  // page table
  logic [PAGES-1:0] used_q;
  logic [IDX_W-1:0] link_q [PAGES];
  logic [CNT_W-1:0] free_q;

  // per-transaction working registers
  cmd_e              op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  prev_q;
  logic              first_q;
  logic [CNT_W-1:0]  left_q;
  logic [CNT_W-1:0]  need_q;
  logic [CNT_W-1:0]  cnt_q;

  // staged result and output register
  status_e             res_status_q;
  logic [PAGE_FW-1:0]  res_first_q;
  logic [COUNT_FW-1:0] res_count_q;
  logic [1:0]          out_status_q;
  logic [PAGE_FW-1:0]  out_first_q;
  logic [COUNT_FW-1:0] out_count_q;
  logic [COUNT_FW-1:0] out_free_q;

  // load decode
  cmd_e              op_in;
  logic [NEED_W-1:0] size_sum;
  logic [NEED_W-1:0] need;
  logic [IDX_W-1:0]  head_idx;
  logic              head_ok;
  logic              no_space;
  status_e           imm_status;
  logic              imm;

  // step logic
  logic             used_here;
  logic [IDX_W-1:0] nxt;
  logic             claim;
  logic             is_free;
  logic             broken;
  logic [CNT_W-1:0] cnt_inc;
  logic             walk_stop;
  logic             alloc_last;

  assign op_in    = cmd_e'(cmd_i);
  assign size_sum = {1'b0, size_bytes_i} + NEED_W'(PAGE_BYTES - 1);
  assign need     = NEED_W'(size_sum / PAGE_BYTES);
  assign head_idx = IDX_W'(head_page_i);
  assign head_ok  = (32'(head_page_i) < PAGES) && used_q[head_idx];
  assign no_space = need > NEED_W'(free_q);

  always_comb begin
    imm        = 1'b0;
    imm_status = ST_OK;
    case (op_in)
      CMD_ALLOC: begin
        if (size_bytes_i == '0) begin
          imm        = 1'b1;
          imm_status = ST_ZERO_SIZE;
        end else if (no_space) begin
          imm        = 1'b1;
          imm_status = ST_NO_SPACE;
        end
      end
      CMD_FREE, CMD_QUERY: begin
        if (!head_ok) begin
          imm        = 1'b1;
          imm_status = ST_NOT_USED;
        end
      end
      default: begin
        // unused code answers ok with nothing done
        imm        = 1'b1;
        imm_status = ST_OK;
      end
    endcase
  end

  assign used_here  = used_q[idx_q];
  assign nxt        = link_q[idx_q];
  assign claim      = !used_here;
  assign alloc_last = claim && (left_q == CNT_W'(1));
  assign is_free    = (op_q == CMD_FREE);
  assign broken     = is_free && !used_here;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign walk_stop  = broken || (nxt == idx_q) || (32'(nxt) >= PAGES)
                      || (32'(cnt_inc) == PAGES);

  assign stat_o.imm        = imm;
  assign stat_o.is_alloc   = (op_in == CMD_ALLOC);
  assign stat_o.alloc_last = alloc_last;
  assign stat_o.walk_stop  = walk_stop;

  // control state of the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      free_q <= CNT_W'(PAGES);
    end else begin
      if (cmd_ctl_i.step_alloc && claim) begin
        used_q[idx_q] <= 1'b1;
        free_q        <= free_q - CNT_W'(1);
      end else if (cmd_ctl_i.step_walk && is_free && !broken) begin
        used_q[idx_q] <= 1'b0;
        free_q        <= free_q + CNT_W'(1);
      end
    end
  end

  // links, working, result and output registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_ctl_i.load) begin
      op_q         <= op_in;
      idx_q        <= (op_in == CMD_ALLOC) ? IDX_W'(PAGES - 1) : head_idx;
      first_q      <= 1'b1;
      left_q       <= CNT_W'(need);
      need_q       <= CNT_W'(need);
      cnt_q        <= '0;
      res_status_q <= imm_status;
      res_first_q  <= '0;
      res_count_q  <= '0;
    end
    if (cmd_ctl_i.step_alloc) begin
      if (claim) begin
        link_q[idx_q] <= first_q ? idx_q : prev_q;
        prev_q        <= idx_q;
        first_q       <= 1'b0;
        left_q        <= left_q - CNT_W'(1);
      end
      idx_q <= idx_q - IDX_W'(1);
      if (alloc_last) begin
        res_status_q <= ST_OK;
        res_first_q  <= PAGE_FW'(idx_q);
        res_count_q  <= COUNT_FW'(need_q);
      end
    end
    if (cmd_ctl_i.step_walk) begin
      if (!broken) begin
        cnt_q <= cnt_inc;
      end
      if (!walk_stop) begin
        idx_q <= nxt;
      end else begin
        res_status_q <= ST_OK;
        res_first_q  <= '0;
        res_count_q  <= broken ? COUNT_FW'(cnt_q) : COUNT_FW'(cnt_inc);
      end
    end
    if (cmd_ctl_i.publish) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_count_q  <= res_count_q;
      out_free_q   <= COUNT_FW'(free_q);
    end
  end

  assign status_o     = out_status_q;
  assign first_page_o = out_first_q;
  assign page_count_o = out_count_q;
  assign free_pages_o = out_free_q;

`include "chained_page_allocator_assert.svh"

  `CPA_ASSERT_IMPL(a_free_matches_used, 1'b1, (32'(free_q) + $countones(used_q)) == PAGES)
  `CPA_ASSERT_IMPL(a_claim_has_space, cmd_ctl_i.step_alloc, free_q != '0 && left_q != '0)
  `CPA_ASSERT_IMPL(a_walk_bound, cmd_ctl_i.step_walk, 32'(cnt_q) < PAGES)

endmodule

`default_nettype wire

/* rtl/chained_page_allocator.sv */
// allocate: accept, scan pages one by one from the top (up to PAGES),
//   then load the output register once it can take the result
// free and query: accept, then walk the chain link by link (up to PAGES);
// errors and the unused code answer without a scan; one transaction at a time
// reset clears every in-use bit and sets the free count to PAGES at once
`default_nettype none

module chained_page_allocator
  import cpa_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [CMD_FW-1:0]   cmd_i,
  input  wire logic [SIZE_FW-1:0]  size_bytes_i,
  input  wire logic [PAGE_FW-1:0]  head_page_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               status_o,
  output logic [PAGE_FW-1:0]       first_page_o,
  output logic [COUNT_FW-1:0]      page_count_o,
  output logic [COUNT_FW-1:0]      free_pages_o
);

  cpa_cmd_t  ctl;
  cpa_stat_t stat;

  cpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (ctl)
  );

  cpa_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .size_bytes_i (size_bytes_i),
    .head_page_i  (head_page_i),
    .cmd_ctl_i    (ctl),
    .stat_o       (stat),
    .status_o     (status_o),
    .first_page_o (first_page_o),
    .page_count_o (page_count_o),
    .free_pages_o (free_pages_o)
  );

endmodule

`default_nettype wire

/* bench/chained_page_allocator_test.sv */
// self-checking testbench of the chained page allocator: directed table, then random traffic
// predicts each untyped answer from a mirror of the page table; depends on cpa_pkg and the rtl
`default_nettype none

module chained_page_allocator_test;
  import cpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS  = 1525;
  localparam int DRAIN_TICKS = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N       = 25;

  typedef struct packed {
    status_e               st;
    logic [PAGE_FW-1:0]    first;
    logic [COUNT_FW-1:0]   count;
    logic [COUNT_FW-1:0]   free_cnt;
  } page_result_t;

  typedef struct packed {
    cmd_e                  cmd;
    logic [SIZE_FW-1:0]    size;
    logic [PAGE_FW-1:0]    head;
    bit                    typed;
    page_result_t          res;
  } table_row_t;

  localparam page_result_t UNTYPED = '{ST_OK, 4'd0, 5'd0, 5'd0};

  // typed answers only where they are plain; the rest come from the mirror
  localparam table_row_t DIR_ROWS [DIR_N] = '{
    '{CMD_QUERY, 12'd0,    4'd0,  1'b1, '{ST_NOT_USED,  4'd0,  5'd0,  5'd16}},
    '{CMD_FREE,  12'd0,    4'd15, 1'b1, '{ST_NOT_USED,  4'd0,  5'd0,  5'd16}},
    '{CMD_ALLOC, 12'd0,    4'd0,  1'b1, '{ST_ZERO_SIZE, 4'd0,  5'd0,  5'd16}},
    '{CMD_ALLOC, 12'd4095, 4'd0,  1'b1, '{ST_NO_SPACE,  4'd0,  5'd0,  5'd16}},
    '{CMD_NOP,   12'd4095, 4'd15, 1'b1, '{ST_OK,        4'd0,  5'd0,  5'd16}},
    '{CMD_ALLOC, 12'd256,  4'd0,  1'b1, '{ST_OK,        4'd0,  5'd16, 5'd0}},
    '{CMD_ALLOC, 12'd1,    4'd0,  1'b1, '{ST_NO_SPACE,  4'd0,  5'd0,  5'd0}},
    '{CMD_QUERY, 12'd0,    4'd0,  1'b1, '{ST_OK,        4'd0,  5'd16, 5'd0}},
    '{CMD_FREE,  12'd0,    4'd0,  1'b1, '{ST_OK,        4'd0,  5'd16, 5'd16}},
    '{CMD_ALLOC, 12'd1,    4'd0,  1'b1, '{ST_OK,        4'd15, 5'd1,  5'd15}},
    '{CMD_ALLOC, 12'd17,   4'd0,  1'b1, '{ST_OK,        4'd13, 5'd2,  5'd13}},
    '{CMD_ALLOC, 12'd16,   4'd0,  1'b1, '{ST_OK,        4'd12, 5'd1,  5'd12}},
    '{CMD_ALLOC, 12'd48,   4'd0,  1'b1, '{ST_OK,        4'd9,  5'd3,  5'd9}},
    // free from mid-chain, then from the head whose next page is gone
    '{CMD_FREE,  12'd0,    4'd10, 1'b0, UNTYPED},
    '{CMD_FREE,  12'd0,    4'd9,  1'b0, UNTYPED},
    '{CMD_QUERY, 12'd0,    4'd13, 1'b0, UNTYPED},
    '{CMD_FREE,  12'd0,    4'd15, 1'b0, UNTYPED},
    // chain over a hole in the table
    '{CMD_ALLOC, 12'd160,  4'd0,  1'b0, UNTYPED},
    '{CMD_QUERY, 12'd0,    4'd3,  1'b0, UNTYPED},
    '{CMD_QUERY, 12'd0,    4'd12, 1'b0, UNTYPED},
    '{CMD_NOP,   12'hAAA,  4'd5,  1'b0, UNTYPED},
    '{CMD_FREE,  12'd0,    4'd3,  1'b0, UNTYPED},
    '{CMD_FREE,  12'd0,    4'd13, 1'b0, UNTYPED},
    '{CMD_FREE,  12'd0,    4'd12, 1'b0, UNTYPED},
    '{CMD_ALLOC, 12'd4080, 4'd0,  1'b1, '{ST_NO_SPACE,  4'd0,  5'd0,  5'd16}}
  };

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [CMD_FW-1:0]   cmd_i        = CMD_NOP;
  logic [SIZE_FW-1:0]  size_bytes_i = '0;
  logic [PAGE_FW-1:0]  head_page_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [1:0]          status_o;
  logic [PAGE_FW-1:0]  first_page_o;
  logic [COUNT_FW-1:0] page_count_o;
  logic [COUNT_FW-1:0] free_pages_o;

  // mirror of the page table
  bit mirror_used [PAGES];
  int mirror_link [PAGES];
  int mirror_free = PAGES;

  page_result_t       pending_page_results [$];
  logic [PAGE_FW-1:0] live_heads [$];
  int fail_count  = 0;
  int cycle_count = 0;
  int send_calm   = 0;
  int recv_calm   = 0;

  chained_page_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .size_bytes_i (size_bytes_i),
    .head_page_i  (head_page_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .first_page_o (first_page_o),
    .page_count_o (page_count_o),
    .free_pages_o (free_pages_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // idle cycles before a transaction or stall cycles before taking a result, with runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  function automatic page_result_t predict_table_op(cmd_e c, logic [SIZE_FW-1:0] size,
                                                    logic [PAGE_FW-1:0] head);
    page_result_t res;
    int need, left, prev, last, idx, cnt;
    res = UNTYPED;
    case (c)
      CMD_ALLOC: begin
        if (size == 0) begin
          res.st = ST_ZERO_SIZE;
        end else begin
          need = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
          if (need > mirror_free) begin
            res.st = ST_NO_SPACE;
          end else begin
            left = need;
            prev = 0;
            last = 0;
            // claim from the top; the first page claimed ends the chain
            for (int i = PAGES - 1; i >= 0 && left > 0; i--) begin
              if (!mirror_used[i]) begin
                if (left == need) prev = i;
                mirror_link[i] = prev;
                mirror_used[i] = 1'b1;
                prev = i;
                last = i;
                left--;
              end
            end
            mirror_free -= need;
            res.first = PAGE_FW'(last);
            res.count = COUNT_FW'(need);
          end
        end
      end
      CMD_FREE, CMD_QUERY: begin
        idx = int'(head);
        if (idx >= PAGES || !mirror_used[idx]) begin
          res.st = ST_NOT_USED;
        end else begin
          cnt = 0;
          for (int s = 0; s < PAGES; s++) begin
            if (c == CMD_FREE) begin
              if (!mirror_used[idx]) break;
              mirror_used[idx] = 1'b0;
              mirror_free++;
            end
            cnt++;
            if (mirror_link[idx] == idx || mirror_link[idx] >= PAGES) break;
            idx = mirror_link[idx];
          end
          res.count = COUNT_FW'(cnt);
        end
      end
      default: ;
    endcase
    res.free_cnt = COUNT_FW'(mirror_free);
    return res;
  endfunction

  function automatic string show_result(page_result_t r);
    return $sformatf("status %0d first %0d count %0d free %0d",
                     r.st, r.first, r.count, r.free_cnt);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic issue_table_op(cmd_e c, logic [SIZE_FW-1:0] size, logic [PAGE_FW-1:0] head,
                                bit typed, page_result_t typed_res);
    int gap;
    page_result_t pred;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    size_bytes_i <= size;
    head_page_i  <= head;
    do @(posedge clk_i); while (!in_ready_o);
    pred = predict_table_op(c, size, head);
    pending_page_results.push_back(typed ? typed_res : pred);
    if (c == CMD_ALLOC && pred.st == ST_OK) live_heads.push_back(pred.first);
  endtask

  // result side stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    page_result_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_e'(status_o), first_page_o, page_count_o, free_pages_o};
      if (pending_page_results.size() == 0) begin
        note_failure($sformatf("unexpected transaction: %s", show_result(got)));
      end else begin
        want = pending_page_results.pop_front();
        if (got.st !== want.st || got.first !== want.first ||
            got.count !== want.count || got.free_cnt !== want.free_cnt) begin
          note_failure($sformatf("expected %s, got %s", show_result(want), show_result(got)));
        end
      end
    end
  end

  initial begin
    int sel, k;
    cmd_e c;
    logic [SIZE_FW-1:0] size;
    logic [PAGE_FW-1:0] head;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++) begin
      issue_table_op(DIR_ROWS[i].cmd, DIR_ROWS[i].size, DIR_ROWS[i].head,
                     DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      sel  = $urandom_range(0, 99);
      size = SIZE_FW'($urandom_range(0, 4095));
      head = PAGE_FW'($urandom_range(0, PAGES - 1));
      if (sel < 38) begin
        c = CMD_ALLOC;
        // mostly a few pages, now and then a big chain
        if ($urandom_range(0, 9) < 8) size = SIZE_FW'($urandom_range(1, 64));
        else size = SIZE_FW'($urandom_range(65, 256));
      end else if (sel < 83) begin
        c = (sel < 63) ? CMD_FREE : CMD_QUERY;
        if (live_heads.size() != 0 && $urandom_range(0, 9) < 7) begin
          k = $urandom_range(0, live_heads.size() - 1);
          head = live_heads[k];
          if (c == CMD_FREE) live_heads.delete(k);
        end
      end else if (sel < 90) begin
        c = CMD_ALLOC;
        if ($urandom_range(0, 1) == 0) size = '0;
      end else begin
        c = CMD_NOP;
      end
      issue_table_op(c, size, head, 1'b0, UNTYPED);
    end
    in_valid_i <= 1'b0;

    while (pending_page_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (fail_count == 0 && pending_page_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/cpa_pkg.sv
rtl/cpa_ctrl.sv
rtl/cpa_dpath.sv
rtl/chained_page_allocator.sv
bench/chained_page_allocator_test.sv
